[rtl/binary_heap_priority_queue_unit_defines.svh]
// Assertion macros for the heap priority queue unit.
// Depends on nothing; included by the top level.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define BHPQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("bhpq check failed");
`define BHPQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("bhpq check failed");
`else
`define BHPQ_ASSERT(label, clk, rst, prop)
`define BHPQ_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[rtl/bhpq_pkg.sv]
// Shared constants and types of the heap priority queue.
// No dependencies.
package bhpq_pkg;
   localparam int CAPACITY = 1024;
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = 11;
   localparam int VW = 31;
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_PEEK   = 2'd3;
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_ABSENT = 2'd3;

   // memory port request from the sequencer
   typedef struct packed {
      logic          we;
      logic [AW-1:0] waddr;
      logic [VW-1:0] wdata;
      logic [AW-1:0] raddr;
   } mem_req_type;
endpackage

[rtl/bhpq_store.sv]
// Heap entry memory: one write port, one registered read port.
// Depends on bhpq_pkg.
module bhpq_store
   import bhpq_pkg::*;
(
   input  logic          clock,
   input  mem_req_type   mem_req,
   output logic [VW-1:0] rd_data
);
   logic [VW-1:0] mem [CAPACITY];

   // write and read in the same edge; read returns the old entry
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rd_data <= mem[mem_req.raddr];
   end
endmodule

[rtl/bhpq_seq.sv]
// Request sequencer: search, sift up and sift down over the entry memory.
// Depends on bhpq_pkg.
module bhpq_seq
   import bhpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    req_op,
   input  logic [VW-1:0] req_value,
   input  logic          max_order,
   input  logic [VW-1:0] rd_data,
   output mem_req_type   mem_req,
   output logic          busy,
   output logic          rsp_valid,
   output logic [VW-1:0] rsp_result_value,
   output logic [1:0]    rsp_status,
   output logic [CW-1:0] rsp_entry_count
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_TOP   = 4'd1;  // read slot 0
   localparam logic [3:0] S_SRCH  = 4'd2;  // linear search
   localparam logic [3:0] S_LAST  = 4'd3;  // read last entry
   localparam logic [3:0] S_UPRD  = 4'd4;  // parent read issued
   localparam logic [3:0] S_UPCMP = 4'd5;
   localparam logic [3:0] S_DNL   = 4'd6;  // left child read issued
   localparam logic [3:0] S_DNCMP = 4'd8;  // right child read issued
   localparam logic [3:0] S_DONE  = 4'd9;
   localparam logic [3:0] S_UPCHK = 4'd10;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    op_ff, op_in;
   logic [VW-1:0] val_ff, val_in;      // request value
   logic [VW-1:0] cur_ff, cur_in;      // value being sifted
   logic [AW-1:0] pos_ff, pos_in;
   logic [CW-1:0] idx_ff, idx_in;      // search index
   logic [VW-1:0] res_ff, res_in;
   logic [1:0]    st_ff, st_in;
   logic [VW-1:0] lch_ff, lch_in;
   logic          up_moved_ff, up_moved_in;
   logic [AW-1:0] hole_ff, hole_in;         // slot refilled by a removal
   logic [VW-1:0] hole_val_ff, hole_val_in; // parent that dropped into that slot
   logic          rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] parent;
   logic [CW-1:0] lidx, ridx;
   logic [AW-1:0] hole_lidx;

   function automatic logic above(input logic mo, input logic [VW-1:0] a,
                                  input logic [VW-1:0] b);
      above = mo ? (a > b) : (a < b);
   endfunction

   assign parent    = AW'((pos_ff - 1'b1) >> 1);
   assign lidx      = CW'({pos_ff, 1'b1});
   assign ridx      = lidx + 1'b1;
   assign hole_lidx = AW'({hole_ff, 1'b1});

   always_comb begin
      state_in = state_ff; count_in = count_ff; op_in = op_ff; val_in = val_ff;
      cur_in = cur_ff; pos_in = pos_ff; idx_in = idx_ff; res_in = res_ff;
      st_in = st_ff; lch_in = lch_ff; up_moved_in = up_moved_ff;
      hole_in = hole_ff; hole_val_in = hole_val_ff;
      rsp_valid_in = 1'b0;
      mem_req = '{we: 1'b0, waddr: '0, wdata: '0, raddr: '0};
      case (state_ff)
         S_IDLE: begin
            if (start && !rsp_valid_ff) begin
               op_in = req_op; val_in = req_value; st_in = ST_OK;
               res_in = req_value;
               if (req_op == OP_INSERT) begin
                  if (count_ff >= CW'(CAPACITY)) begin
                     st_in = ST_FULL; state_in = S_DONE;
                  end else begin
                     cur_in = req_value; pos_in = AW'(count_ff);
                     count_in = count_ff + 1'b1; up_moved_in = 1'b1;
                     state_in = S_UPCHK;
                  end
               end else if (count_ff == '0) begin
                  st_in = ST_EMPTY;
                  if (req_op != OP_REMOVE) res_in = '0;
                  state_in = S_DONE;
               end else if (req_op == OP_REMOVE) begin
                  mem_req.raddr = '0; idx_in = '0; state_in = S_SRCH;
               end else begin
                  mem_req.raddr = '0; state_in = S_TOP;
               end
            end
         end
         S_TOP: begin
            res_in = rd_data;
            if (op_ff == OP_PEEK) begin
               state_in = S_DONE;
            end else begin
               pos_in = '0; count_in = count_ff - 1'b1;
               if (count_ff == CW'(1)) begin
                  state_in = S_DONE;
               end else begin
                  mem_req.raddr = AW'(count_ff - 1'b1); state_in = S_LAST;
               end
            end
         end
         S_SRCH: begin
            // data for idx_ff is on rd_data
            if (rd_data == val_ff) begin
               pos_in = AW'(idx_ff); count_in = count_ff - 1'b1;
               if (idx_ff == count_ff - 1'b1) begin
                  state_in = S_DONE;
               end else begin
                  mem_req.raddr = AW'(count_ff - 1'b1); state_in = S_LAST;
               end
            end else if (idx_ff + 1'b1 == count_ff) begin
               st_in = ST_ABSENT; state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1; mem_req.raddr = AW'(idx_ff + 1'b1);
            end
         end
         S_LAST: begin
            cur_in = rd_data; up_moved_in = 1'b0; hole_in = pos_ff;
            state_in = S_UPCHK;
         end
         S_UPCHK: begin
            // write current into pos and fetch parent if any
            mem_req.we = 1'b1; mem_req.waddr = pos_ff; mem_req.wdata = cur_ff;
            if (pos_ff == '0) begin
               if (!up_moved_ff) begin
                  mem_req.raddr = AW'(lidx); state_in = S_DNL;
               end else if (op_ff == OP_INSERT) begin
                  state_in = S_DONE;
               end else begin
                  // climb finished; sink the displaced parent from the refilled slot
                  pos_in = hole_ff; cur_in = hole_val_ff;
                  mem_req.raddr = hole_lidx; state_in = S_DNL;
               end
               up_moved_in = 1'b0;
            end else begin
               mem_req.raddr = parent; state_in = S_UPRD;
            end
         end
         S_UPRD: begin
            if (above(max_order, cur_ff, rd_data)) begin
               // move parent down, climb
               mem_req.we = 1'b1; mem_req.waddr = pos_ff; mem_req.wdata = rd_data;
               if (!up_moved_ff) hole_val_in = rd_data;
               pos_in = parent; up_moved_in = 1'b1; state_in = S_UPCHK;
            end else if (op_ff == OP_INSERT) begin
               state_in = S_DONE;
            end else if (up_moved_ff) begin
               // climb finished; sink the displaced parent from the refilled slot
               pos_in = hole_ff; cur_in = hole_val_ff;
               mem_req.raddr = hole_lidx; state_in = S_DNL;
            end else begin
               mem_req.raddr = AW'(lidx); state_in = S_DNL;
            end
         end
         S_DNL: begin
            // rd_data holds the left child
            if (lidx >= count_ff) begin
               state_in = S_DONE;
            end else begin
               lch_in = rd_data;
               mem_req.raddr = AW'(ridx); state_in = S_DNCMP;
            end
         end
         S_DNCMP: begin
            // rd_data holds right child if it exists
            if (ridx < count_ff && above(max_order, rd_data, lch_ff) &&
                above(max_order, rd_data, cur_ff)) begin
               mem_req.we = 1'b1; mem_req.waddr = pos_ff; mem_req.wdata = rd_data;
               mem_req.raddr = AW'({AW'(ridx), 1'b1});
               pos_in = AW'(ridx); state_in = S_DNL;
               mem_req.we = 1'b1;
            end else if (above(max_order, lch_ff, cur_ff)) begin
               mem_req.we = 1'b1; mem_req.waddr = pos_ff; mem_req.wdata = lch_ff;
               mem_req.raddr = AW'({AW'(lidx), 1'b1});
               pos_in = AW'(lidx); state_in = S_DNL;
            end else begin
               state_in = S_DONE;
            end
            if (state_in == S_DNL) begin
               // keep current; it is written where it stops sinking
               cur_in = cur_ff;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // sinking writes current at its final position once it stops
      if (state_ff == S_DNL && !(lidx >= count_ff)) begin
         mem_req.we = 1'b0;
      end
      if (state_ff == S_DNL && lidx >= count_ff) begin
         mem_req.we = 1'b1; mem_req.waddr = pos_ff; mem_req.wdata = cur_ff;
      end
      if (state_ff == S_DNCMP && state_in == S_DONE) begin
         mem_req.we = 1'b1; mem_req.waddr = pos_ff; mem_req.wdata = cur_ff;
      end
   end

   // advance state; reset clears control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in; val_ff <= val_in; cur_ff <= cur_in; pos_ff <= pos_in;
      idx_ff <= idx_in; res_ff <= res_in; st_ff <= st_in; lch_ff <= lch_in;
      up_moved_ff <= up_moved_in; hole_ff <= hole_in; hole_val_ff <= hole_val_in;
   end

   assign busy             = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = res_ff;
   assign rsp_status       = st_ff;
   assign rsp_entry_count  = count_ff;
endmodule

[rtl/binary_heap_priority_queue_unit.sv]
// Heap priority queue: insert, remove top, remove value, peek; min or max heap.
// A remove-value request first searches the entries one by one; each sift level reads
// the entry memory and compares, and a removal may climb then sink.
// One request at a time; busy stays high until the result strobe has passed.
// Synchronous reset empties the heap and selects min order; the receiver cannot stall.
`include "binary_heap_priority_queue_unit_defines.svh"
module binary_heap_priority_queue_unit
   import bhpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic [1:0]    req_op,
   input  logic [VW-1:0] req_value,
   input  logic          csr_we,
   input  logic          csr_wdata,
   output logic          rsp_valid,
   output logic [VW-1:0] rsp_result_value,
   output logic [1:0]    rsp_status,
   output logic [CW-1:0] rsp_entry_count
);
   logic          max_order_ff;
   mem_req_type   mem_req;
   logic [VW-1:0] rd_data;

   // hold order bit
   always_ff @(posedge clock) begin
      if (reset) begin
         max_order_ff <= 1'b0;
      end else if (csr_we) begin
         max_order_ff <= csr_wdata;
      end
   end

   bhpq_store u_store (.clock(clock), .mem_req(mem_req), .rd_data(rd_data));

   bhpq_seq u_seq (
      .clock(clock), .reset(reset), .start(start), .req_op(req_op),
      .req_value(req_value), .max_order(max_order_ff), .rd_data(rd_data),
      .mem_req(mem_req), .busy(busy), .rsp_valid(rsp_valid),
      .rsp_result_value(rsp_result_value), .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count)
   );

   `BHPQ_ASSERT(a_count_max, clock, reset, rsp_entry_count <= CW'(CAPACITY))
   `BHPQ_ASSERT(a_rsp_busy, clock, reset, rsp_valid |-> busy)
   `BHPQ_ASSERT(a_full_st, clock, reset, (rsp_valid && rsp_status == ST_FULL) |-> rsp_entry_count == CW'(CAPACITY))
   `BHPQ_ASSERT(a_empty_st, clock, reset, (rsp_valid && rsp_status == ST_EMPTY) |-> rsp_entry_count == '0)
endmodule

[verif/bhpq_scoreboard.sv]
// Scoreboard for the heap priority queue unit: watches requests, order writes and responses.
// Keeps its own heap and compares every response; depends on bhpq_pkg.
module bhpq_scoreboard
   import bhpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          busy,
   input  logic [1:0]    req_op,
   input  logic [VW-1:0] req_value,
   input  logic          csr_we,
   input  logic          csr_wdata,
   input  logic          rsp_valid,
   input  logic [VW-1:0] rsp_result_value,
   input  logic [1:0]    rsp_status,
   input  logic [CW-1:0] rsp_entry_count,
   output int            fail_count,
   output int            pending,
   output int            answered
);
   typedef struct packed {
      logic [VW-1:0] value;
      logic [1:0]    status;
      logic [CW-1:0] count;
   } heap_answer_type;

   logic [VW-1:0]   heap_copy [CAPACITY];
   int              held;
   logic            largest_on_top;
   heap_answer_type awaited [$];

   // true when a belongs above b in the current order
   function automatic bit outranks(logic [VW-1:0] a, logic [VW-1:0] b);
      return largest_on_top ? (a > b) : (a < b);
   endfunction

   function automatic void swap_entries(int x, int y);
      logic [VW-1:0] t;
      t = heap_copy[x];
      heap_copy[x] = heap_copy[y];
      heap_copy[y] = t;
   endfunction

   function automatic void float_up(int p);
      int up;
      while (p > 0) begin
         up = (p - 1) / 2;
         if (!outranks(heap_copy[p], heap_copy[up])) break;
         swap_entries(p, up);
         p = up;
      end
   endfunction

   function automatic void sink_down(int p);
      int l, r, best;
      forever begin
         l = 2 * p + 1;
         r = 2 * p + 2;
         best = p;
         if (l < held && outranks(heap_copy[l], heap_copy[best])) best = l;
         if (r < held && outranks(heap_copy[r], heap_copy[best])) best = r;
         if (best == p) break;
         swap_entries(p, best);
         p = best;
      end
   endfunction

   // remove the entry at p and fill the hole with the last one
   function automatic void take_entry(int p);
      held--;
      if (p < held) begin
         heap_copy[p] = heap_copy[held];
         float_up(p);
         sink_down(p);
      end
   endfunction

   function automatic heap_answer_type serve_request(logic [1:0] op, logic [VW-1:0] val);
      heap_answer_type a;
      int i;
      a.value  = '0;
      a.status = ST_OK;
      case (op)
         OP_INSERT: begin
            a.value = val;
            if (held >= CAPACITY) a.status = ST_FULL;
            else begin
               heap_copy[held] = val;
               held++;
               float_up(held - 1);
            end
         end
         OP_POP: begin
            if (held == 0) a.status = ST_EMPTY;
            else begin
               a.value = heap_copy[0];
               take_entry(0);
            end
         end
         OP_REMOVE: begin
            a.value = val;
            if (held == 0) a.status = ST_EMPTY;
            else begin
               for (i = 0; i < held; i++)
                  if (heap_copy[i] == val) break;
               if (i == held) a.status = ST_ABSENT;
               else take_entry(i);
            end
         end
         default: begin
            if (held == 0) a.status = ST_EMPTY;
            else a.value = heap_copy[0];
         end
      endcase
      a.count = held[CW-1:0];
      return a;
   endfunction

   task automatic report_mismatch(string what, logic [VW-1:0] got, logic [VW-1:0] want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      answered = 0;
      held = 0;
      largest_on_top = 1'b0;
   end

   assign pending = awaited.size();

   // check the response first, then take in the request of this edge
   always @(posedge clock) begin
      heap_answer_type want;
      if (reset) begin
         held = 0;
         largest_on_top = 1'b0;
         awaited.delete();
      end else begin
         if (rsp_valid) begin
            answered++;
            if (awaited.size() == 0) begin
               report_mismatch("response with no request outstanding",
                               rsp_result_value, '0);
            end else begin
               want = awaited.pop_front();
               if (rsp_result_value !== want.value)
                  report_mismatch("result_value", rsp_result_value, want.value);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_entry_count !== want.count)
                  report_mismatch("entry_count", rsp_entry_count, want.count);
            end
         end
         if (csr_we) largest_on_top = csr_wdata;
         if (start && !busy) awaited.push_back(serve_request(req_op, req_value));
      end
   end
endmodule

[verif/binary_heap_priority_queue_unit_tb.sv]
// Testbench top for the heap priority queue unit: clock, reset, request stimulus, verdict.
// Depends on bhpq_pkg, the unit itself and bhpq_scoreboard.
module binary_heap_priority_queue_unit_tb;
   import bhpq_pkg::*;

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   logic [1:0]    req_op;
   logic [VW-1:0] req_value;
   logic          csr_we;
   logic          csr_wdata;
   logic          rsp_valid;
   logic [VW-1:0] rsp_result_value;
   logic [1:0]    rsp_status;
   logic [CW-1:0] rsp_entry_count;
   int            fail_count;
   int            pending;
   int            answered;
   int            sent;
   bit            steady;

   binary_heap_priority_queue_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_value(req_value),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_result_value(rsp_result_value),
      .rsp_status(rsp_status), .rsp_entry_count(rsp_entry_count)
   );

   bhpq_scoreboard scoreboard (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_value(req_value),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_result_value(rsp_result_value),
      .rsp_status(rsp_status), .rsp_entry_count(rsp_entry_count),
      .fail_count(fail_count), .pending(pending), .answered(answered)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop if the unit hangs
   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end

   // one request: optional idle gap, then hold start until the unit takes it
   task automatic send_request(logic [1:0] op, logic [VW-1:0] val);
      bit taken;
      if (!steady && $urandom_range(0, 99) < 16) begin
         start = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      start = 1'b1;
      req_op = op;
      req_value = val;
      do begin
         taken = !busy;
         @(negedge clock);
      end while (!taken);
      sent++;
   endtask

   // drop start and wait until every response is back and the unit is free
   task automatic drain_outstanding();
      start = 1'b0;
      while (pending != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_order(logic largest);
      drain_outstanding();
      csr_we = 1'b1;
      csr_wdata = largest;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // mostly a small pool so duplicates and hits are common, plus extremes and full range
   function automatic logic [VW-1:0] pick_value();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return VW'($urandom_range(0, 15));
         5:             return {VW{1'b1}} - VW'($urandom_range(0, 3));
         6:             return '0;
         default:       return r[VW-1:0];
      endcase
   endfunction

   // weights: insert, pop, remove value, peek out of a hundred
   task automatic random_burst(int n, int w_ins, int w_pop, int w_rem);
      int k;
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < w_ins) send_request(OP_INSERT, pick_value());
         else if (r < w_ins + w_pop) send_request(OP_POP, pick_value());
         else if (r < w_ins + w_pop + w_rem) send_request(OP_REMOVE, pick_value());
         else send_request(OP_PEEK, pick_value());
         k = $urandom_range(0, 59);
         if (k == 0) drain_outstanding();
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_op = OP_PEEK;
      req_value = '0;
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      sent = 0;
      steady = 1'b0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // directed: empty heap, extremes, duplicates, absent value, order flip
      write_order(1'b0);
      send_request(OP_PEEK, '0);
      send_request(OP_POP, {VW{1'b1}});
      send_request(OP_REMOVE, 31'd5);
      send_request(OP_INSERT, '0);
      send_request(OP_INSERT, {VW{1'b1}});
      send_request(OP_INSERT, {VW{1'b1}});
      send_request(OP_INSERT, 31'h2AAA_AAAA);
      send_request(OP_INSERT, 31'h5555_5555);
      send_request(OP_REMOVE, 31'd9);
      send_request(OP_REMOVE, {VW{1'b1}});
      send_request(OP_PEEK, '0);
      write_order(1'b1);
      send_request(OP_PEEK, '0);
      send_request(OP_INSERT, 31'd1);
      send_request(OP_POP, '0);
      send_request(OP_REMOVE, '0);
      send_request(OP_POP, '0);
      send_request(OP_POP, '0);
      send_request(OP_POP, '0);
      send_request(OP_POP, '0);
      send_request(OP_REMOVE, 31'd1);

      // random mixes under both orders
      write_order(1'b0);
      random_burst(200, 45, 20, 20);
      write_order(1'b1);
      random_burst(200, 40, 25, 20);
      steady = 1'b1;
      random_burst(120, 35, 25, 20);
      steady = 1'b0;

      // grow a deep heap without idling, then work on it and flip order
      write_order(1'b0);
      steady = 1'b1;
      for (int i = 0; i < 200; i++) send_request(OP_INSERT, pick_value());
      steady = 1'b0;
      random_burst(16, 50, 20, 15);
      write_order(1'b1);
      random_burst(16, 30, 40, 15);
      for (int i = 0; i < 120; i++) begin
         if ($urandom_range(0, 9) == 0) send_request(OP_PEEK, '0);
         else send_request(OP_POP, '0);
      end

      // short heap mix to close
      write_order(1'b0);
      random_burst(50, 40, 25, 25);

      drain_outstanding();
      repeat (30) @(posedge clock);
      $display("Covered %0d requests (%0d responses): empty, absent and duplicate cases,",
               sent, answered);
      $display("deep heaps, both orders, order flips with entries held, and request gaps.");
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
